// ===== src/sbfr_pkg.sv =====
`default_nettype none

package sbfr_pkg;

	// Sizes
	localparam int NUM_BARS_DEF = 8;
	localparam int FIELD_BARS   = 8;
	localparam int LVL_W        = 12;
	localparam int DELTA_W      = 20;
	localparam int CFG_W        = 24;
	localparam int CFG_IDX_W    = 2;
	localparam int PIX_W        = 6;
	localparam int ROWS         = 8;
	localparam int CHAN_W       = 8;
	localparam int MIX_W        = 11;
	localparam int FALL_SHIFT   = 20;

	// Level ceiling, 8.0 in 4.8 fixed point
	localparam logic [LVL_W-1:0] LEVEL_MAX = 12'd2048;

	// x / 7 for x < 5461: (x * 2341) >> 14
	localparam int               DIV7_W     = 23;
	localparam logic [11:0]      DIV7_MUL   = 12'd2341;
	localparam int               DIV7_SHIFT = 14;

	// Row colour preparation: one mix per row plus a final drain step
	localparam int                PREP_CNT_W = 4;
	localparam logic [PREP_CNT_W-1:0] PREP_LAST = 4'd8;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FALL_RATE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER_COLOR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER_COLOR = 2'd2;

	// Register reset values
	localparam logic [CFG_W-1:0] FALL_RATE_RST   = 24'd10737;
	localparam logic [CFG_W-1:0] LOWER_COLOR_RST = 24'd6579300;
	localparam logic [CFG_W-1:0] UPPER_COLOR_RST = 24'd16716800;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_EMIT
	} sbfr_state_t;

	typedef struct packed {
		logic [DELTA_W-1:0] delta_us;
		logic [LVL_W-1:0]   target_0;
		logic [LVL_W-1:0]   target_1;
		logic [LVL_W-1:0]   target_2;
		logic [LVL_W-1:0]   target_3;
		logic [LVL_W-1:0]   target_4;
		logic [LVL_W-1:0]   target_5;
		logic [LVL_W-1:0]   target_6;
		logic [LVL_W-1:0]   target_7;
	} sbfr_frame_t;

	typedef struct packed {
		logic [PIX_W-1:0]  pixel_index;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              last;
	} sbfr_pixel_t;

	typedef struct packed {
		logic       load;
		logic [2:0] mix_row;
		logic       color_wr;
		logic       upd_levels;
		logic       emit;
	} sbfr_cmd_t;

	typedef struct packed {
		logic out_free;
		logic last_pix;
	} sbfr_stat_t;

endpackage

`default_nettype wire

// ===== src/spectrum_bar_falloff_renderer.sv =====
// Bar graph renderer for an 8x8 LED matrix with falling bar levels.
// Input channel (in_valid/in_ready/in_item): one frame item with the elapsed
// microseconds and eight target heights in 4.8 fixed point. Output channel
// (out_valid/out_ready/out_item): 64 pixel items per frame, pixel_index 0..63,
// last set on pixel 63. Configuration channel (cfg_valid/cfg_ready/cfg_index/
// cfg_data): fall rate, lower and upper row colour; always ready, write only
// while no frame is in flight.
// Timing: a frame is taken in the idle state, then the preparation state builds
// the decay product and the eight row colours (one mix and one divide-by-seven
// per row), the levels update, and pixels are loaded into the output register at
// one per cycle while the output register is free. With the receiver always ready
// a frame spans the idle state, the preparation steps and one load per pixel.
// Stall: with out_ready low a waiting pixel stays in the output register and the
// counter waits. The next frame may be accepted while pixel 63 still waits.
// Reset: bar levels clear to zero, registers take their default values, both
// channels come up empty and the block is ready for a frame.
`default_nettype none

module spectrum_bar_falloff_renderer import sbfr_pkg::*; #(
	parameter int NUM_BARS = NUM_BARS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  sbfr_frame_t               in_item,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output sbfr_pixel_t               out_item,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	sbfr_cmd_t  cmd;
	sbfr_stat_t stat;

	assign cfg_ready = 1'b1;

	sbfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sbfr_dp #(
		.NUM_BARS (NUM_BARS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

	// A taken frame leaves the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("frame accepted but block still ready");

	// Loading the final pixel returns the block to idle
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && stat.last_pix |=> in_ready)
		else $error("block not idle after final pixel");

	// No pixel is produced while waiting for a frame
	a_no_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !cmd.emit)
		else $error("pixel emitted while idle");

	// An emitted pixel appears on the output
	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid)
		else $error("emitted pixel not presented");

endmodule

`default_nettype wire

// ===== src/sbfr_ctrl.sv =====
`default_nettype none

module sbfr_ctrl import sbfr_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  sbfr_stat_t      stat,
	output sbfr_cmd_t       cmd
);

	sbfr_state_t             state_q, state_d;
	logic [PREP_CNT_W-1:0]   prep_cnt_q, prep_cnt_d;

	// State and preparation counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			prep_cnt_q <= '0;
		end else begin
			state_q    <= state_d;
			prep_cnt_q <= prep_cnt_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d        = state_q;
		prep_cnt_d     = prep_cnt_q;
		in_ready       = 1'b0;
		cmd            = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load   = 1'b1;
					prep_cnt_d = '0;
					state_d    = ST_PREP;
				end
			end
			ST_PREP: begin
				// mix row n while row n-1 is divided and stored
				cmd.mix_row  = prep_cnt_q[2:0];
				cmd.color_wr = (prep_cnt_q != '0);
				if (prep_cnt_q == PREP_LAST) begin
					cmd.upd_levels = 1'b1;
					state_d        = ST_EMIT;
				end else begin
					prep_cnt_d = prep_cnt_q + 1'b1;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.last_pix) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/sbfr_dp.sv =====
`default_nettype none

module sbfr_dp import sbfr_pkg::*; #(
	parameter int NUM_BARS = NUM_BARS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  sbfr_frame_t               in_item,
	input  wire logic                 cfg_valid,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  sbfr_cmd_t                 cmd,
	output sbfr_stat_t                stat,
	input  wire logic                 out_ready,
	output logic                      out_valid,
	output sbfr_pixel_t               out_item
);

	localparam int BAR_W  = (NUM_BARS > 1) ? $clog2(NUM_BARS) : 1;
	localparam int PROD_W = DELTA_W + CFG_W;

	logic [CFG_W-1:0]   fall_rate_q, lower_color_q, upper_color_q;
	logic [DELTA_W-1:0] delta_q;
	logic [LVL_W-1:0]   tgt_in [FIELD_BARS];
	logic [LVL_W-1:0]   tgt_q  [FIELD_BARS];
	logic [PROD_W-1:0]  prod;
	logic [CFG_W-1:0]   dec_q;
	logic [LVL_W-1:0]   lvl_q  [NUM_BARS];
	logic [LVL_W-1:0]   lvl_d  [NUM_BARS];

	logic [MIX_W-1:0]   mix_sum [3];
	logic [MIX_W-1:0]   mix_s1  [3];
	logic [2:0]         mix_row_s1;
	logic [CFG_W-1:0]   div_color;
	logic [CFG_W-1:0]   row_color_q [ROWS];

	logic [PIX_W-1:0]   pix_cnt_q;
	logic [2:0]         pix_y, pix_bar;
	logic [BAR_W-1:0]   bar_idx;
	logic [LVL_W-1:0]   level, y_base, prev_base, frac_full;
	logic               full, partial;
	logic [CFG_W-1:0]   rc;
	logic [CFG_W-1:0]   shade;
	sbfr_pixel_t        pixel;
	sbfr_pixel_t        out_q;
	logic               out_valid_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fall_rate_q   <= FALL_RATE_RST;
			lower_color_q <= LOWER_COLOR_RST;
			upper_color_q <= UPPER_COLOR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FALL_RATE:   fall_rate_q   <= cfg_data;
				CFG_LOWER_COLOR: lower_color_q <= cfg_data;
				CFG_UPPER_COLOR: upper_color_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Targets, saturated at 8.0 when captured
	assign tgt_in[0] = in_item.target_0;
	assign tgt_in[1] = in_item.target_1;
	assign tgt_in[2] = in_item.target_2;
	assign tgt_in[3] = in_item.target_3;
	assign tgt_in[4] = in_item.target_4;
	assign tgt_in[5] = in_item.target_5;
	assign tgt_in[6] = in_item.target_6;
	assign tgt_in[7] = in_item.target_7;

	// Frame capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			delta_q <= in_item.delta_us;
			for (int i = 0; i < FIELD_BARS; i++) begin
				tgt_q[i] <= (tgt_in[i] > LEVEL_MAX) ? LEVEL_MAX : tgt_in[i];
			end
		end
	end

	// Fall per frame: (delta * rate) >> 20
	assign prod = PROD_W'(delta_q) * PROD_W'(fall_rate_q);

	always_ff @(posedge clk) begin
		dec_q <= prod[PROD_W-1:FALL_SHIFT];
	end

	// Level update, one lane per bar
	for (genvar i = 0; i < NUM_BARS; i++) begin : g_bar
		logic [LVL_W-1:0] fallen, tgt;
		assign fallen = (dec_q >= CFG_W'(lvl_q[i])) ? '0 : lvl_q[i] - dec_q[LVL_W-1:0];
		if (i < FIELD_BARS) begin : g_tgt
			assign tgt = tgt_q[i];
		end else begin : g_no_tgt
			assign tgt = '0;
		end
		assign lvl_d[i] = (tgt > fallen) ? tgt : fallen;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BARS; i++) begin
				lvl_q[i] <= '0;
			end
		end else if (cmd.upd_levels) begin
			lvl_q <= lvl_d;
		end
	end

	// Row colour mix: lower*(7-y) + upper*y per channel
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			mix_sum[c] = MIX_W'(lower_color_q[c*CHAN_W +: CHAN_W]) * MIX_W'(3'd7 - cmd.mix_row)
				+ MIX_W'(upper_color_q[c*CHAN_W +: CHAN_W]) * MIX_W'(cmd.mix_row);
		end
	end

	always_ff @(posedge clk) begin
		mix_s1     <= mix_sum;
		mix_row_s1 <= cmd.mix_row;
	end

	// Divide by seven through the reciprocal
	always_comb begin
		logic [DIV7_W-1:0] q;
		for (int c = 0; c < 3; c++) begin
			q = DIV7_W'(mix_s1[c]) * DIV7_W'(DIV7_MUL);
			div_color[c*CHAN_W +: CHAN_W] = q[DIV7_SHIFT +: CHAN_W];
		end
	end

	// Row colour store
	always_ff @(posedge clk) begin
		if (cmd.color_wr) begin
			row_color_q[mix_row_s1] <= div_color;
		end
	end

	// Pixel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_cnt_q <= '0;
		end else if (cmd.load) begin
			pix_cnt_q <= '0;
		end else if (cmd.emit) begin
			pix_cnt_q <= pix_cnt_q + 1'b1;
		end
	end

	// Pixel shading; column x shows bar 7-x
	assign pix_y   = pix_cnt_q[5:3];
	assign pix_bar = 3'd7 - pix_cnt_q[2:0];
	assign bar_idx = BAR_W'(pix_bar);
	assign level   = (int'(pix_bar) < NUM_BARS) ? lvl_q[bar_idx] : '0;

	assign y_base    = {1'b0, pix_y, 8'b0};
	assign prev_base = y_base - 12'd256;
	assign frac_full = level - prev_base;
	assign full      = (level > y_base);
	assign partial   = (pix_y != 3'd0) && (level > prev_base) && (level < y_base);
	assign rc        = row_color_q[pix_y];

	always_comb begin
		logic [2*CHAN_W-1:0] p;
		for (int c = 0; c < 3; c++) begin
			p = (2*CHAN_W)'(rc[c*CHAN_W +: CHAN_W]) * (2*CHAN_W)'(frac_full[CHAN_W-1:0]);
			if (full) begin
				shade[c*CHAN_W +: CHAN_W] = rc[c*CHAN_W +: CHAN_W];
			end else if (partial) begin
				shade[c*CHAN_W +: CHAN_W] = p[2*CHAN_W-1:CHAN_W];
			end else begin
				shade[c*CHAN_W +: CHAN_W] = '0;
			end
		end
	end

	always_comb begin
		pixel.pixel_index = pix_cnt_q;
		pixel.red         = shade[2*CHAN_W +: CHAN_W];
		pixel.green       = shade[CHAN_W +: CHAN_W];
		pixel.blue        = shade[0 +: CHAN_W];
		pixel.last        = &pix_cnt_q;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= pixel;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_item      = out_q;
	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.last_pix = &pix_cnt_q;

endmodule

`default_nettype wire

// ===== tb/tb_spectrum_bar_falloff_renderer.sv =====
`default_nettype none

module tb_spectrum_bar_falloff_renderer;
	timeunit 1ns;
	timeprecision 1ps;

	import sbfr_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int RESET_CYCLES = 8;
	localparam int IDLE_GAP     = 8;
	localparam int DRAIN_CYCLES = 20;
	localparam int LONG_HOLD    = 300;
	localparam int PHASES       = 6;
	localparam int PHASE_FRAMES = 17;
	localparam int PIXELS       = 64;
	localparam int LEVEL_ONE    = 256;
	localparam int TIMEOUT_NS   = 20_000_000;

	// Index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef logic [FIELD_BARS-1:0][LVL_W-1:0] bar_set_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	sbfr_frame_t          in_item   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	sbfr_pixel_t          out_item;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	// Shadow copy of the registers and the kept bar levels
	logic [CFG_W-1:0] fall_rate_r = FALL_RATE_RST;
	logic [CFG_W-1:0] lower_rgb   = LOWER_COLOR_RST;
	logic [CFG_W-1:0] upper_rgb   = UPPER_COLOR_RST;
	logic [LVL_W-1:0] bar_height [FIELD_BARS] = '{default: '0};

	sbfr_pixel_t pixel_q [$];

	int fail_count     = 0;
	int frames_sent    = 0;
	int pixels_checked = 0;
	int partial_pixels = 0;
	int reg_writes     = 0;

	// Receiver control
	logic no_idle    = 1'b0;
	logic hold_on    = 1'b0;
	logic hold_done  = 1'b0;
	int   hold_cnt   = 0;
	int   stall_left = 0;

	spectrum_bar_falloff_renderer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Row colour: per-channel blend from bottom to top row, truncated
	function automatic int unsigned row_mix(input logic [7:0] lo, hi, input int unsigned y);
		return (lo * (ROWS - 1 - y) + hi * y) / (ROWS - 1);
	endfunction

	// Decay, raise and clamp the bar levels, then queue the 64 pixels of the frame
	function automatic void predict_frame(input sbfr_frame_t frame);
		bar_set_t     tgt;
		logic [43:0]  fall;
		int unsigned  lvl, t, y, frac, r, g, b;
		sbfr_pixel_t  px;
		tgt  = {frame.target_7, frame.target_6, frame.target_5, frame.target_4,
			frame.target_3, frame.target_2, frame.target_1, frame.target_0};
		fall = (44'(frame.delta_us) * 44'(fall_rate_r)) >> FALL_SHIFT;
		for (int i = 0; i < FIELD_BARS; i++) begin
			lvl = (fall >= bar_height[i]) ? 0 : bar_height[i] - fall[LVL_W-1:0];
			t   = (tgt[i] > LEVEL_MAX) ? LEVEL_MAX : tgt[i];
			if (t > lvl)
				lvl = t;
			if (lvl > LEVEL_MAX)
				lvl = LEVEL_MAX;
			bar_height[i] = LVL_W'(lvl);
		end
		for (int p = 0; p < PIXELS; p++) begin
			y   = p / ROWS;
			lvl = bar_height[ROWS - 1 - p % ROWS];
			r   = row_mix(lower_rgb[23:16], upper_rgb[23:16], y);
			g   = row_mix(lower_rgb[15:8], upper_rgb[15:8], y);
			b   = row_mix(lower_rgb[7:0], upper_rgb[7:0], y);
			if (lvl <= y * LEVEL_ONE) begin
				if (y > 0 && lvl > (y - 1) * LEVEL_ONE && lvl < y * LEVEL_ONE) begin
					// part-lit: scale by the fraction of the row below
					frac = lvl - (y - 1) * LEVEL_ONE;
					r    = (r * frac) >> 8;
					g    = (g * frac) >> 8;
					b    = (b * frac) >> 8;
					partial_pixels++;
				end else begin
					r = 0;
					g = 0;
					b = 0;
				end
			end
			px.pixel_index = PIX_W'(p);
			px.red         = CHAN_W'(r);
			px.green       = CHAN_W'(g);
			px.blue        = CHAN_W'(b);
			px.last        = (p == PIXELS - 1);
			pixel_q = {pixel_q, px};
		end
	endfunction

	function automatic sbfr_frame_t make_frame(input logic [DELTA_W-1:0] delta, input bar_set_t tv);
		sbfr_frame_t f;
		f.delta_us = delta;
		{f.target_7, f.target_6, f.target_5, f.target_4,
			f.target_3, f.target_2, f.target_1, f.target_0} = tv;
		return f;
	endfunction

	// Mostly short frame times and in-range heights; some zero heights so bars fall
	function automatic sbfr_frame_t random_frame();
		bar_set_t             tv;
		logic [DELTA_W-1:0]   delta;
		int unsigned          mode;
		mode = $urandom_range(0, 9);
		if (mode < 5)
			delta = DELTA_W'($urandom_range(0, 3000));
		else if (mode < 8)
			delta = DELTA_W'($urandom_range(0, 65535));
		else
			delta = DELTA_W'($urandom);
		for (int i = 0; i < FIELD_BARS; i++) begin
			mode = $urandom_range(0, 7);
			if (mode < 3)
				tv[i] = '0;
			else if (mode < 6)
				tv[i] = LVL_W'($urandom_range(0, LEVEL_MAX));
			else if (mode == 6)
				tv[i] = LVL_W'($urandom_range(LEVEL_MAX, 4095));
			else
				tv[i] = LVL_W'($urandom_range(1, ROWS) * LEVEL_ONE
					+ $urandom_range(0, 2) - 1);
		end
		return make_frame(delta, tv);
	endfunction

	// One frame item, with an occasional idle burst ahead of it
	task automatic send_frame(input sbfr_frame_t frame);
		int unsigned gap;
		gap = (!no_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_item  <= frame;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_frame(frame);
		frames_sent++;
	endtask

	// Stop offering frames and let every queued pixel come out
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_FALL_RATE:   fall_rate_r = data;
			CFG_LOWER_COLOR: lower_rgb   = data;
			CFG_UPPER_COLOR: upper_rgb   = data;
			default: ;
		endcase
		reg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(input logic [CFG_W-1:0] rate, lower, upper);
		wait_idle();
		write_reg(CFG_FALL_RATE, rate);
		write_reg(CFG_LOWER_COLOR, lower);
		write_reg(CFG_UPPER_COLOR, upper);
	endtask

	// Reset values: blank, full, saturating and part-lit bars, plus a huge fall
	task automatic test_defaults();
		send_frame(make_frame('0, '0));
		send_frame(make_frame('0, {FIELD_BARS{LEVEL_MAX}}));
		send_frame(make_frame('1, '0));
		send_frame(make_frame('0, {12'd2047, 12'd1792, 12'd1279, 12'd511,
			12'd257, 12'd256, 12'd255, 12'd1}));
		send_frame(make_frame('0, {12'd4095, 12'd2049, 12'd3000, 12'd2304,
			12'd0, 12'd0, 12'd0, 12'd0}));
		send_frame(make_frame(20'd5000, '0));
		send_frame(make_frame(20'd1, '0));
	endtask

	// Register extremes, the unused index and levels sitting on row boundaries
	task automatic test_registers();
		wait_idle();
		write_reg(CFG_UNUSED, '1);
		set_regs('0, '0, '1);
		send_frame(make_frame('1, {12'd2048, 12'd1792, 12'd1536, 12'd1280,
			12'd1024, 12'd768, 12'd512, 12'd256}));
		send_frame(make_frame('1, '0));
		set_regs('1, '1, '0);
		send_frame(make_frame(20'd1, '0));
		send_frame(make_frame('1, '0));
		send_frame(make_frame('0, {12'd2048, 12'd1537, 12'd1023, 12'd700,
			12'd300, 12'd128, 12'd64, 12'd2}));
	endtask

	// One level unit per microsecond: watch full bars fall through part-lit rows
	task automatic test_decay();
		set_regs(24'd1 << FALL_SHIFT, 24'h00FF00, 24'hFF00FF);
		send_frame(make_frame('0, {FIELD_BARS{LEVEL_MAX}}));
		send_frame(make_frame(20'd1, '0));
		send_frame(make_frame(20'd255, '0));
		send_frame(make_frame(20'd256, '0));
		send_frame(make_frame(20'd700, '0));
		send_frame(make_frame(20'd1000, '0));
	endtask

	// Long output hold while frames keep coming, then a full drain
	task automatic test_backpressure();
		set_regs(FALL_RATE_RST, LOWER_COLOR_RST, UPPER_COLOR_RST);
		hold_on <= 1'b1;
		repeat (3) send_frame(random_frame());
		hold_on <= 1'b0;
		wait_idle();
	endtask

	// Random frames across several register settings; last phase runs flat out
	task automatic test_random();
		logic [CFG_W-1:0] rate;
		for (int ph = 0; ph < PHASES; ph++) begin
			rate = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom)
				: CFG_W'($urandom_range(0, 40000));
			set_regs(rate, CFG_W'($urandom), CFG_W'($urandom));
			if (ph == PHASES - 1)
				no_idle <= 1'b1;
			repeat (PHASE_FRAMES) send_frame(random_frame());
		end
	endtask

	// Receiver: random stall bursts, or one long hold counted here
	always @(posedge clk) begin
		if (hold_on && !hold_done) begin
			out_ready <= 1'b0;
			hold_cnt  <= hold_cnt + 1;
			if (hold_cnt == LONG_HOLD - 1)
				hold_done <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!no_idle && $urandom_range(0, 5) == 0) begin
			out_ready  <= 1'b0;
			stall_left <= $urandom_range(0, 2);
		end else begin
			out_ready <= 1'b1;
		end
		if (!hold_on) begin
			hold_cnt  <= 0;
			hold_done <= 1'b0;
		end
	end

	task automatic compare_field(input string name, input logic [7:0] want, got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Pixel checker: each accepted pixel against the oldest expected one
	always @(posedge clk) begin
		sbfr_pixel_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pixel_q.size() == 0) begin
				$error("pixel %0d arrived with nothing expected", out_item.pixel_index);
				fail_count++;
			end else begin
				want = pixel_q.pop_front();
				compare_field("pixel_index", 8'(want.pixel_index), 8'(out_item.pixel_index));
				compare_field("red", want.red, out_item.red);
				compare_field("green", want.green, out_item.green);
				compare_field("blue", want.blue, out_item.blue);
				compare_field("last", 8'(want.last), 8'(out_item.last));
				pixels_checked++;
			end
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_registers();
		test_decay();
		test_backpressure();
		test_random();
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pixel_q.size() != 0) begin
			$error("%0d pixels never arrived", pixel_q.size());
			fail_count++;
		end
		$display("covered %0d frames, %0d pixels (%0d part-lit), %0d register writes,",
			frames_sent, pixels_checked, partial_pixels, reg_writes);
		$display("random stalls on both sides and one long output hold");
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
src/sbfr_pkg.sv
src/sbfr_ctrl.sv
src/sbfr_dp.sv
src/spectrum_bar_falloff_renderer.sv
tb/tb_spectrum_bar_falloff_renderer.sv
